### rtl/core/rtvc_pkg.sv
// Shared constants and types for the RGB to HSV converter.
// Used by the interfaces, the front stage and the top level.
`timescale 1ns / 1ps

package rtvc_pkg;

  localparam int unsigned ChanW      = 8;   // width of one colour channel
  localparam int unsigned HueBitsDef = 16;  // default hue resolution
  localparam int unsigned HueOutW    = 16;  // width of the hue field
  localparam int unsigned SatW       = 16;  // width of the saturation field
  localparam int unsigned HueDenW    = 11;  // holds 6 * (max - min) up to 1530

  // Values that ride beside the dividers to the output stage
  typedef struct packed {
    logic [ChanW-1:0] delta;    // max - min
    logic [ChanW-1:0] hi;       // largest channel
    logic [ChanW-1:0] alpha;
    logic             sat_full; // min is 0 and max is not: saturation is full scale
  } side_t;

  // Front stage result: divider operands plus side band
  typedef struct packed {
    logic [HueDenW-1:0] hue_num;
    logic [HueDenW-1:0] hue_den;
    logic [ChanW-1:0]   sat_num;
    logic [ChanW-1:0]   sat_den;
    side_t              side;
  } front_t;

endpackage

### rtl/core/rtvc_if.sv
// Valid/ready stream interfaces for pixels in and HSV results out.
// Field widths come from rtvc_pkg.
`timescale 1ns / 1ps

interface rtvc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rtvc_pkg::ChanW-1:0] red;
  logic [rtvc_pkg::ChanW-1:0] green;
  logic [rtvc_pkg::ChanW-1:0] blue;
  logic [rtvc_pkg::ChanW-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface rtvc_hsv_if;
  logic                         valid;
  logic                         ready;
  logic [rtvc_pkg::HueOutW-1:0] hue;
  logic [rtvc_pkg::SatW-1:0]    saturation;
  logic [rtvc_pkg::ChanW-1:0]   brightness;
  logic [rtvc_pkg::ChanW-1:0]   alpha_out;

  modport source (output valid, output hue, output saturation, output brightness,
                  output alpha_out, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input alpha_out, output ready);
endinterface

### rtl/core/rtvc_front.sv
// First pipeline stage: max, min, hue sector and the operands of both dividers.
// Depends on rtvc_pkg.
`timescale 1ns / 1ps

module rtvc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rtvc_pkg::ChanW-1:0] red_i,
  input  logic [rtvc_pkg::ChanW-1:0] green_i,
  input  logic [rtvc_pkg::ChanW-1:0] blue_i,
  input  logic [rtvc_pkg::ChanW-1:0] alpha_i,
  output logic                       valid_o,
  output rtvc_pkg::front_t           front_o
);

  localparam int unsigned ChanW = rtvc_pkg::ChanW;
  localparam int unsigned DenW  = rtvc_pkg::HueDenW;

  logic [ChanW-1:0] hi, lo, delta;
  logic             red_max, green_max;
  logic [DenW:0]    d2, d4, d6, num_wide, num_wrap;
  logic             valid_q;
  rtvc_pkg::front_t front_d, front_q;

  always_comb begin
    hi = (red_i > green_i) ? red_i : green_i;
    hi = (hi > blue_i) ? hi : blue_i;
    lo = (red_i < green_i) ? red_i : green_i;
    lo = (lo < blue_i) ? lo : blue_i;
    delta = hi - lo;

    red_max   = (hi == red_i);
    green_max = !red_max && (hi == green_i);

    d2 = (DenW+1)'(delta) << 1;
    d4 = (DenW+1)'(delta) << 2;
    d6 = d2 + d4;

    // Bias every sector so the numerator never goes negative
    if (red_max) begin
      num_wide = d6 + (DenW+1)'(green_i) - (DenW+1)'(blue_i);
      num_wrap = (num_wide >= d6) ? (num_wide - d6) : num_wide;
    end else if (green_max) begin
      num_wide = d2 + (DenW+1)'(blue_i) - (DenW+1)'(red_i);
      num_wrap = num_wide;
    end else begin
      num_wide = d4 + (DenW+1)'(red_i) - (DenW+1)'(green_i);
      num_wrap = num_wide;
    end

    front_d.side.delta    = delta;
    front_d.side.hi       = hi;
    front_d.side.alpha    = alpha_i;
    front_d.side.sat_full = (lo == '0) && (hi != '0);

    // Grey: divide zero by one so the hue comes out as zero
    if (delta == '0) begin
      front_d.hue_num = '0;
      front_d.hue_den = DenW'(1);
    end else begin
      front_d.hue_num = num_wrap[DenW-1:0];
      front_d.hue_den = d6[DenW-1:0];
    end

    // Fractional divide needs num < den; full scale and black go around it
    if (front_d.side.sat_full || hi == '0) begin
      front_d.sat_num = '0;
      front_d.sat_den = ChanW'(1);
    end else begin
      front_d.sat_num = delta;
      front_d.sat_den = hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign valid_o = valid_q;
  assign front_o = front_q;

endmodule

### rtl/core/rtvc_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Gives floor(num * 2^QBits / den) for num < den; leading stages only delay.
`timescale 1ns / 1ps

module rtvc_div #(
  parameter int unsigned W      = 8,
  parameter int unsigned Stages = 16,
  parameter int unsigned QBits  = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [W-1:0]     num_i,
  input  logic [W-1:0]     den_i,
  output logic [QBits-1:0] quo_o,
  output logic [W-1:0]     rem_o
);

  localparam int unsigned FirstBit = Stages - QBits;

  logic [W-1:0]     rem_src [Stages];
  logic [W-1:0]     den_src [Stages];
  logic [QBits-1:0] quo_src [Stages];
  logic [W:0]       trial   [Stages];
  logic [W-1:0]     rem_d   [Stages];
  logic [QBits-1:0] quo_d   [Stages];
  logic [W-1:0]     rem_q   [Stages];
  logic [W-1:0]     den_q   [Stages];
  logic [QBits-1:0] quo_q   [Stages];

  always_comb begin
    rem_src[0] = num_i;
    den_src[0] = den_i;
    quo_src[0] = '0;
    for (int k = 1; k < Stages; k++) begin
      rem_src[k] = rem_q[k-1];
      den_src[k] = den_q[k-1];
      quo_src[k] = quo_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < Stages; k++) begin
      trial[k] = {rem_src[k], 1'b0};
      if (k >= FirstBit) begin
        if (trial[k] >= {1'b0, den_src[k]}) begin
          rem_d[k] = W'(trial[k] - {1'b0, den_src[k]});
          quo_d[k] = {quo_src[k][QBits-2:0], 1'b1};
        end else begin
          rem_d[k] = trial[k][W-1:0];
          quo_d[k] = {quo_src[k][QBits-2:0], 1'b0};
        end
      end else begin
        rem_d[k] = rem_src[k];
        quo_d[k] = quo_src[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Stages; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_src[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[Stages-1];
  assign rem_o = rem_q[Stages-1];

endmodule

### rtl/core/rgb_to_hsv_converter_core.sv
// RGB to HSV converter: takes one RGBA pixel per cycle and returns hue, saturation,
// brightness (the largest channel) and alpha. The pipeline is one front stage, then
// max(HueBits, 16) stages in each of the hue and saturation divider pipelines (one per
// quotient bit of the wider result), and the output register. A new pixel is accepted
// every cycle unless the output stalls; a stall at the output freezes the whole pipeline.
// Depends on rtvc_pkg, rtvc_if, rtvc_front and rtvc_div.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_core #(
  parameter int unsigned HueBits = rtvc_pkg::HueBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rtvc_pix_if.sink         pix_i,
  rtvc_hsv_if.source       hsv_o
);

  localparam int unsigned ChanW   = rtvc_pkg::ChanW;
  localparam int unsigned SatW    = rtvc_pkg::SatW;
  localparam int unsigned HueOutW = rtvc_pkg::HueOutW;
  localparam int unsigned Stages  = (HueBits > SatW) ? HueBits : SatW;
  localparam int unsigned HueW    = (HueBits > HueOutW) ? HueBits : HueOutW;

  logic                  adv;
  logic                  front_valid;
  rtvc_pkg::front_t      front;
  logic [HueBits-1:0]    hue_quo;
  logic [rtvc_pkg::HueDenW-1:0] hue_rem;
  logic [SatW-1:0]       sat_quo;
  logic [ChanW-1:0]      sat_rem;
  logic                  side_valid_q [Stages];
  rtvc_pkg::side_t       side_q       [Stages];
  rtvc_pkg::side_t       side_last;
  logic [HueW-1:0]       hue_wide;
  logic [SatW-1:0]       sat_d;
  logic                  hsv_valid_q;
  logic [HueOutW-1:0]    hue_q;
  logic [SatW-1:0]       sat_q;
  logic [ChanW-1:0]      bright_q;
  logic [ChanW-1:0]      alpha_q;

  // Advance everything when the output register is free or being drained
  assign adv         = !hsv_valid_q || hsv_o.ready;
  assign pix_i.ready = adv;

  rtvc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .alpha_i (pix_i.alpha),
    .valid_o (front_valid),
    .front_o (front)
  );

  rtvc_div #(
    .W      (rtvc_pkg::HueDenW),
    .Stages (Stages),
    .QBits  (HueBits)
  ) u_hue_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (front.hue_num),
    .den_i (front.hue_den),
    .quo_o (hue_quo),
    .rem_o (hue_rem)
  );

  rtvc_div #(
    .W      (ChanW),
    .Stages (Stages),
    .QBits  (SatW)
  ) u_sat_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (front.sat_num),
    .den_i (front.sat_den),
    .quo_o (sat_quo),
    .rem_o (sat_rem)
  );

  // Side band kept in step with the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) begin
        side_valid_q[k] <= 1'b0;
      end
    end else if (adv) begin
      side_valid_q[0] <= front_valid;
      for (int k = 1; k < Stages; k++) begin
        side_valid_q[k] <= side_valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= front.side;
      for (int k = 1; k < Stages; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_last = side_q[Stages-1];
  assign hue_wide  = HueW'(hue_quo);

  // floor(d*65535/max) is floor(d*65536/max), less one when the remainder is below d
  always_comb begin
    if (side_last.sat_full) begin
      sat_d = '1;
    end else begin
      sat_d = sat_quo - SatW'(sat_rem < side_last.delta);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsv_valid_q <= 1'b0;
    end else if (adv) begin
      hsv_valid_q <= side_valid_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue_q    <= hue_wide[HueOutW-1:0];
      sat_q    <= sat_d;
      bright_q <= side_last.hi;
      alpha_q  <= side_last.alpha;
    end
  end

  assign hsv_o.valid      = hsv_valid_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = bright_q;
  assign hsv_o.alpha_out  = alpha_q;

`ifndef SYNTHESIS
  // Zero saturation only comes from a grey pixel, whose hue is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_q && (sat_q == '0) |-> (hue_q == '0))
    else $error("nonzero hue on a grey pixel");

  // A black pixel has no saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_q && (bright_q == '0) |-> (sat_q == '0))
    else $error("saturation set on a black pixel");

  // Full scale saturation needs a nonzero brightness
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_valid_q && (sat_q == '1) |-> (bright_q != '0))
    else $error("full saturation with zero brightness");

  // A grey pixel divides zero by one, so no hue remainder is left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_valid_q[Stages-1] && (side_last.delta == '0) |-> (hue_rem == '0))
    else $error("hue remainder left on a grey pixel");

  // A stalled pipeline holds its valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(side_valid_q[Stages-1]) && $stable(front_valid))
    else $error("pipeline moved during a stall");
`endif

endmodule
